@@ design/dual_goertzel_signal_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Dual Goertzel signal detector: assertion macros
// Shared check macros; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef DUAL_GOERTZEL_SIGNAL_DETECTOR_DEFINES_SVH
`define DUAL_GOERTZEL_SIGNAL_DETECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DGSD_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("dgsd check failed");
`define DGSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dgsd check failed");
`else
`define DGSD_ASSERT(label, expr)
`define DGSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/dgsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual Goertzel signal detector package
// Sizes, register indexes and types shared by the detector modules.
// ----------------------------------------------------------------------------
package dgsd_pkg;
  localparam int VectorSize = 256;
  localparam int SineDepth  = 1024;
  localparam int SineBits   = $clog2(SineDepth);
  localparam int CountW     = $clog2(VectorSize);
  localparam int TapW       = 48;
  localparam int NumTaps    = 8;
  localparam int QueueDepth = 2;

  localparam logic [15:0] SinA = 16'd51472;
  localparam logic [15:0] SinB = 16'd21024;
  localparam logic [15:0] SinC = 16'd2320;

  localparam logic [2:0] RegMixEnable     = 3'd0;
  localparam logic [2:0] RegPhaseStep     = 3'd1;
  localparam logic [2:0] RegLateralCoeff  = 3'd2;
  localparam logic [2:0] RegAverageEnable = 3'd3;
  localparam logic [2:0] RegSmoothAlpha   = 3'd4;
  localparam logic [2:0] RegThreshold     = 3'd5;

  typedef logic signed [TapW-1:0] tap_t;
  // Order: DC s1/s2 for I, DC s1/s2 for Q, lateral s1/s2 for I, lateral s1/s2 for Q.
  typedef tap_t [NumTaps-1:0] tap_set_t;

  typedef struct packed {
    logic               mix_enable;
    logic [15:0]        phase_step;
    logic signed [16:0] lateral_coeff;
    logic               average_enable;
    logic [15:0]        smoothing_alpha;
    logic [15:0]        threshold;
  } cfg_t;
endpackage

@@ design/dgsd_front.sv @@
// ----------------------------------------------------------------------------
// Dual Goertzel front end
// Takes samples, mixes them by the NCO when enabled and runs both Goertzel
// recurrences on one shared multiplier; hands the taps of each finished vector to the queue.
// ----------------------------------------------------------------------------
module dgsd_front import dgsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] sample_i,
  input  logic signed [15:0] sample_q,
  input  logic               last,
  output logic               push,
  output tap_set_t           push_taps,
  input  logic               queue_full
);
  localparam logic [1:0] FIdle = 2'd0;
  localparam logic [1:0] FMul  = 2'd1;
  localparam logic [1:0] FPush = 2'd2;

  // Sub-steps of the quarter-wave sine polynomial.
  localparam logic [1:0] SqX   = 2'd0;
  localparam logic [1:0] SqC   = 2'd1;
  localparam logic [1:0] SqT   = 2'd2;
  localparam logic [1:0] SqOut = 2'd3;

  localparam logic [3:0] MsSin   = 4'd0;
  localparam logic [3:0] MsMixI  = 4'd8;
  localparam logic [3:0] MsMixI2 = 4'd9;
  localparam logic [3:0] MsMixQ  = 4'd10;
  localparam logic [3:0] MsMixQ2 = 4'd11;
  localparam logic [3:0] MsLatI  = 4'd12;
  localparam logic [3:0] MsLatI2 = 4'd13;
  localparam logic [3:0] MsLatQ  = 4'd14;
  localparam logic [3:0] MsLatQ2 = 4'd15;

  logic [1:0]          state;
  logic [3:0]          mstep;
  logic                ph;
  logic signed [15:0]  xi, xq, xm_i, xm_q, sinv, cosv;
  logic [15:0]         x2, t;
  logic signed [65:0]  acc;
  logic signed [42:0]  prod;
  logic                vec_end;
  tap_set_t            taps;
  logic [15:0]         phase;
  logic [CountW-1:0]   count;

  logic [16:0]         u, uu;
  logic [15:0]         x_cur;
  logic [17:0]         sq_raw;
  logic [15:0]         sq_clip;
  logic signed [15:0]  sres;
  logic signed [24:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic                sel_q;
  tap_t                s1_lat, s2_lat, s1_dc, s2_dc;
  logic signed [15:0]  x_g;
  logic signed [65:0]  mix_sum, mix_sh, lat_full, lat_sh;
  logic signed [15:0]  mix_sat;
  tap_t                s0_lat, s0_dc;

  function automatic tap_t sat48(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF_FFFF) begin
      return {1'b0, {(TapW-1){1'b1}}};
    end else if (v < -66'sh0_8000_0000_0000) begin
      return {1'b1, {(TapW-1){1'b0}}};
    end
    return v[TapW-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    if (v > 66'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -66'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Table index truncates the phase, then maps back onto the 2^17-per-turn scale.
  assign u = {phase[15 -: SineBits], {(17-SineBits){1'b0}}};
  assign uu = mstep[2] ? u + 17'd32768 : u;
  assign x_cur = uu[15] ? 16'd32768 - {1'b0, uu[14:0]} : {1'b0, uu[14:0]};
  assign sq_raw = prod[32:15];
  assign sq_clip = (sq_raw > 18'd32767) ? 16'd32767 : sq_raw[15:0];
  assign sres = uu[16] ? -$signed(sq_clip) : $signed(sq_clip);

  assign sel_q = mstep[1];
  assign s1_lat = sel_q ? taps[6] : taps[4];
  assign s2_lat = sel_q ? taps[7] : taps[5];
  assign s1_dc  = sel_q ? taps[2] : taps[0];
  assign s2_dc  = sel_q ? taps[3] : taps[1];
  assign x_g    = sel_q ? xm_q : xm_i;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (!mstep[3]) begin
      unique case (mstep[1:0])
        SqX: begin
          mul_a = {9'b0, x_cur};
          mul_b = {2'b0, x_cur};
        end
        SqC: begin
          mul_a = {9'b0, x2};
          mul_b = {2'b0, SinC};
        end
        SqT: begin
          mul_a = {9'b0, x2};
          mul_b = {2'b0, t};
        end
        SqOut: begin
          mul_a = {9'b0, x_cur};
          mul_b = {2'b0, t};
        end
        default: ;
      endcase
    end else begin
      unique case (mstep)
        MsMixI: begin
          mul_a = 25'(xi);
          mul_b = 18'(cosv);
        end
        MsMixI2: begin
          mul_a = 25'(xq);
          mul_b = 18'(sinv);
        end
        MsMixQ: begin
          mul_a = 25'(xq);
          mul_b = 18'(cosv);
        end
        MsMixQ2: begin
          mul_a = 25'(xi);
          mul_b = 18'(sinv);
        end
        MsLatI, MsLatQ: begin
          mul_a = {1'b0, s1_lat[23:0]};
          mul_b = 18'(cfg.lateral_coeff);
        end
        MsLatI2, MsLatQ2: begin
          mul_a = {s1_lat[TapW-1], s1_lat[TapW-1:24]};
          mul_b = 18'(cfg.lateral_coeff);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mix_sum  = (mstep == MsMixQ2) ? acc - 66'(prod) : acc + 66'(prod);
    mix_sh   = mix_sum >>> 15;
    mix_sat  = sat16(mix_sh);
    // The 48-bit tap is split into a signed high and unsigned low half.
    lat_full = acc + (66'(prod) <<< 24);
    lat_sh   = lat_full >>> 14;
    s0_lat   = sat48(66'(x_g) + lat_sh - 66'(s2_lat));
    s0_dc    = sat48(66'(x_g) + (66'(s1_dc) <<< 1) - 66'(s2_dc));
  end

  assign sample_stall = (state != FIdle);
  assign push = (state == FPush) && !queue_full;
  assign push_taps = taps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FIdle;
      mstep <= MsSin;
      ph    <= 1'b0;
      taps  <= '0;
      phase <= '0;
      count <= '0;
    end else begin
      unique case (state)
        FIdle: begin
          if (sample_valid) begin
            xi      <= sample_i;
            xq      <= sample_q;
            xm_i    <= sample_i;
            xm_q    <= sample_q;
            vec_end <= last || (count == CountW'(VectorSize - 1));
            mstep   <= cfg.mix_enable ? MsSin : MsLatI;
            ph      <= 1'b0;
            state   <= FMul;
          end
        end
        FMul: begin
          ph <= !ph;
          if (!ph) begin
            prod <= mul_a * mul_b;
          end else begin
            mstep <= mstep + 4'd1;
            if (!mstep[3]) begin
              unique case (mstep[1:0])
                SqX: x2 <= prod[30:15];
                SqC: t <= SinB - prod[30:15];
                SqT: t <= SinA - prod[30:15];
                SqOut: begin
                  if (mstep[2]) begin
                    cosv <= sres;
                  end else begin
                    sinv <= sres;
                  end
                end
                default: ;
              endcase
            end else begin
              unique case (mstep)
                MsMixI, MsMixQ, MsLatI, MsLatQ: acc <= 66'(prod);
                MsMixI2: xm_i <= mix_sat;
                MsMixQ2: xm_q <= mix_sat;
                MsLatI2: begin
                  taps[4] <= s0_lat;
                  taps[5] <= taps[4];
                  taps[0] <= s0_dc;
                  taps[1] <= taps[0];
                end
                MsLatQ2: begin
                  taps[6] <= s0_lat;
                  taps[7] <= taps[6];
                  taps[2] <= s0_dc;
                  taps[3] <= taps[2];
                  phase   <= phase + cfg.phase_step;
                  if (vec_end) begin
                    state <= FPush;
                  end else begin
                    count <= count + CountW'(1);
                    state <= FIdle;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        FPush: begin
          if (!queue_full) begin
            taps  <= '0;
            phase <= '0;
            count <= '0;
            state <= FIdle;
          end
        end
        default: state <= FIdle;
      endcase
    end
  end
endmodule

@@ design/dgsd_queue.sv @@
// ----------------------------------------------------------------------------
// Dual Goertzel tap queue
// Short queue of finished tap sets between the front end and the back end.
// ----------------------------------------------------------------------------
`include "dual_goertzel_signal_detector_defines.svh"
module dgsd_queue import dgsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tap_set_t push_data,
  output logic     full,
  input  logic     pop,
  output tap_set_t pop_data,
  output logic     empty
);
  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  tap_set_t        entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  `DGSD_ASSERT(q_no_overflow, !(push && full))
  `DGSD_ASSERT(q_no_underflow, !(pop && empty))
  `DGSD_ASSERT_NEXT(q_count_up, push && !pop, count == $past(count) + CntW'(1))
endmodule

@@ design/dgsd_back.sv @@
// ----------------------------------------------------------------------------
// Dual Goertzel back end
// Scales a vector's taps, forms both bin energies, divides them or saturates
// the ratio, smooths it if averaging is on, issues one decision per vector.
// ----------------------------------------------------------------------------
module dgsd_back import dgsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        smooth_clear,
  input  logic        q_empty,
  input  tap_set_t    q_taps,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        detected,
  output logic        run_start,
  output logic [15:0] metric
);
  localparam logic [3:0] BIdle   = 4'd0;
  localparam logic [3:0] BMax    = 4'd1;
  localparam logic [3:0] BNorm   = 4'd2;
  localparam logic [3:0] BScale  = 4'd3;
  localparam logic [3:0] BMul    = 4'd4;
  localparam logic [3:0] BDivChk = 4'd5;
  localparam logic [3:0] BDiv    = 4'd6;
  localparam logic [3:0] BAvg    = 4'd7;
  localparam logic [3:0] BAvg2   = 4'd8;
  localparam logic [3:0] BOut    = 4'd9;
  localparam logic [3:0] BWait   = 4'd10;

  localparam logic [2:0] KdDc    = 3'd0;
  localparam logic [2:0] KdL0    = 3'd1;
  localparam logic [2:0] KdL1    = 3'd2;
  localparam logic [2:0] KdCo    = 3'd3;
  localparam logic [2:0] KdCross = 3'd4;

  logic [3:0]         state;
  tap_set_t           taps;
  logic [2:0]         idx;
  logic [TapW-1:0]    maxabs;
  logic [4:0]         sh;
  logic signed [23:0] sc [NumTaps];
  logic               pair;
  logic [2:0]         kind;
  logic               ph;
  logic signed [58:0] prod;
  logic signed [26:0] tmp;
  logic [49:0]        edc;
  logic signed [55:0] elat;
  logic [57:0]        rem;
  logic [70:0]        dsh;
  logic [3:0]         dcnt;
  logic [15:0]        quo, ratio, level;
  logic [31:0]        smooth;
  logic               run_open;

  logic [TapW-1:0]    mag;
  logic signed [23:0] scaled;
  logic signed [24:0] dd;
  logic signed [33:0] diff, mul_a;
  logic signed [24:0] mul_b;
  logic [57:0]        numer;
  logic [55:0]        den;
  logic               fits;
  logic [15:0]        quo_next;
  logic [31:0]        smooth_next;
  logic               det;

  assign mag    = taps[0][TapW-1] ? TapW'(-$signed(taps[0])) : taps[0];
  assign scaled = 24'($signed(taps[0]) >>> sh);
  assign dd     = 25'(sc[0]) - 25'(sc[1]);
  assign diff   = $signed({2'b0, ratio, 16'b0}) - $signed({2'b0, smooth});
  assign numer  = {edc, 8'b0};
  assign den    = elat;
  assign fits   = {13'b0, rem} >= dsh;
  assign quo_next = {quo[14:0], fits};
  assign smooth_next = 32'(34'(smooth) + 34'(prod >>> 16));
  assign det    = level >= cfg.threshold;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == BAvg) begin
      mul_a = diff;
      mul_b = {9'b0, cfg.smoothing_alpha};
    end else begin
      unique case (kind)
        KdDc: begin
          mul_a = 34'(dd);
          mul_b = dd;
        end
        KdL0: begin
          mul_a = 34'(sc[4]);
          mul_b = 25'(sc[4]);
        end
        KdL1: begin
          mul_a = 34'(sc[5]);
          mul_b = 25'(sc[5]);
        end
        KdCo: begin
          mul_a = 34'(cfg.lateral_coeff);
          mul_b = 25'(sc[4]);
        end
        KdCross: begin
          mul_a = 34'(tmp);
          mul_b = 25'(sc[5]);
        end
        default: ;
      endcase
    end
  end

  assign pop = (state == BIdle) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BIdle;
      result_valid <= 1'b0;
      run_open     <= 1'b0;
      smooth       <= '0;
      ph           <= 1'b0;
      kind         <= KdDc;
      pair         <= 1'b0;
    end else begin
      unique case (state)
        BIdle: begin
          if (!q_empty) begin
            taps   <= q_taps;
            idx    <= '0;
            maxabs <= '0;
            sh     <= '0;
            state  <= BMax;
          end
        end
        BMax: begin
          if (mag > maxabs) begin
            maxabs <= mag;
          end
          taps <= {taps[0], taps[NumTaps-1:1]};
          idx  <= idx + 3'd1;
          if (idx == 3'(NumTaps - 1)) begin
            state <= BNorm;
          end
        end
        BNorm: begin
          // Shift until the largest magnitude is below 2^23.
          if (|maxabs[TapW-1:23]) begin
            maxabs <= maxabs >> 1;
            sh     <= sh + 5'd1;
          end else begin
            state <= BScale;
          end
        end
        BScale: begin
          for (int k = 0; k < NumTaps - 1; k++) begin
            sc[k] <= sc[k+1];
          end
          sc[NumTaps-1] <= scaled;
          taps <= {taps[0], taps[NumTaps-1:1]};
          idx  <= idx + 3'd1;
          if (idx == 3'(NumTaps - 1)) begin
            pair  <= 1'b0;
            kind  <= KdDc;
            ph    <= 1'b0;
            edc   <= '0;
            elat  <= '0;
            state <= BMul;
          end
        end
        BMul: begin
          ph <= !ph;
          if (!ph) begin
            prod <= mul_a * mul_b;
          end else begin
            kind <= kind + 3'd1;
            unique case (kind)
              KdDc: edc <= edc + prod[49:0];
              KdL0, KdL1: elat <= elat + 56'(prod);
              KdCo: tmp <= 27'(prod >>> 14);
              KdCross: begin
                elat <= elat - 56'(prod);
                kind <= KdDc;
                if (!pair) begin
                  // Move the Q taps into the places the I taps used.
                  pair  <= 1'b1;
                  sc[0] <= sc[2];
                  sc[1] <= sc[3];
                  sc[4] <= sc[6];
                  sc[5] <= sc[7];
                end else begin
                  state <= BDivChk;
                end
              end
              default: ;
            endcase
          end
        end
        BDivChk: begin
          if (elat <= 56'sd0 || ({14'b0, numer} >= {den, 16'b0})) begin
            ratio <= 16'hFFFF;
            state <= BAvg;
          end else begin
            rem   <= numer;
            dsh   <= 71'(den) << 15;
            dcnt  <= '0;
            quo   <= '0;
            state <= BDiv;
          end
        end
        BDiv: begin
          if (fits) begin
            rem <= rem - dsh[57:0];
          end
          quo  <= quo_next;
          dsh  <= dsh >> 1;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            ratio <= quo_next;
            state <= BAvg;
          end
        end
        BAvg: begin
          if (cfg.average_enable) begin
            prod  <= mul_a * mul_b;
            state <= BAvg2;
          end else begin
            level <= ratio;
            state <= BOut;
          end
        end
        BAvg2: begin
          smooth <= smooth_next;
          level  <= smooth_next[31:16];
          state  <= BOut;
        end
        BOut: begin
          detected     <= det;
          run_start    <= det && !run_open;
          metric       <= level;
          run_open     <= det;
          result_valid <= 1'b1;
          state        <= BWait;
        end
        BWait: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= BIdle;
          end
        end
        default: state <= BIdle;
      endcase
      if (smooth_clear) begin
        smooth <= '0;
      end
    end
  end
endmodule

@@ design/dual_goertzel_signal_detector.sv @@
// ----------------------------------------------------------------------------
// Dual Goertzel signal detector
// Per-vector DC versus lateral bin energy detector on complex samples.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  sample_i, sample_q, last
//   result    out        result_valid / result_stall  detected, run_start, metric
//   config    in         write_enable                 write_index, write_data
//
// The front end's single multiplier forms the sine, cosine and mix products of a
// sample only with mixing enabled, and its lateral products always. The last sample
// of a vector also pushes its taps into a two-entry queue.
// The back end handles each vector, plus any result stall, with scaling, energies
// and the 16-step divider, overlapped with the next vector's samples.
// Reset is synchronous; control state clears and config registers take defaults.
// Samples stall only while the front end is busy, including on a full queue.
// ----------------------------------------------------------------------------
module dual_goertzel_signal_detector import dgsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] sample_i,
  input  logic signed [15:0] sample_q,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               detected,
  output logic               run_start,
  output logic [15:0]        metric,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [16:0]        write_data
);
  cfg_t     cfg;
  logic     smooth_clear;
  logic     push, pop, queue_full, queue_empty;
  tap_set_t push_taps, pop_taps;

  // Changing the averaging setup restarts the smoothed ratio.
  assign smooth_clear = write_enable &&
                        (write_index == RegAverageEnable || write_index == RegSmoothAlpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mix_enable      <= 1'b0;
      cfg.phase_step      <= '0;
      cfg.lateral_coeff   <= '0;
      cfg.average_enable  <= 1'b0;
      cfg.smoothing_alpha <= 16'd655;
      cfg.threshold       <= 16'd461;
    end else if (write_enable) begin
      unique case (write_index)
        RegMixEnable:     cfg.mix_enable      <= write_data[0];
        RegPhaseStep:     cfg.phase_step      <= write_data[15:0];
        RegLateralCoeff:  cfg.lateral_coeff   <= write_data;
        RegAverageEnable: cfg.average_enable  <= write_data[0];
        RegSmoothAlpha:   cfg.smoothing_alpha <= write_data[15:0];
        RegThreshold:     cfg.threshold       <= write_data[15:0];
        default: ;
      endcase
    end
  end

  dgsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_i     (sample_i),
    .sample_q     (sample_q),
    .last         (last),
    .push         (push),
    .push_taps    (push_taps),
    .queue_full   (queue_full)
  );

  dgsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_taps),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_taps),
    .empty     (queue_empty)
  );

  dgsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .smooth_clear (smooth_clear),
    .q_empty      (queue_empty),
    .q_taps       (pop_taps),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .detected     (detected),
    .run_start    (run_start),
    .metric       (metric)
  );
endmodule
